// File: hw/rtl/qpt_pkg.sv
package qpt_pkg;

	// Field widths.
	localparam int Q_WIDTH     = 16;
	localparam int SCALE_WIDTH = 48;
	localparam int SC_WIDTH    = 16;
	localparam int COORD_WIDTH = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;

	// Datapath widths.
	localparam int QPROD_W     = 2 * Q_WIDTH;
	localparam int MAT_W       = QPROD_W + 2;
	localparam int SPT_W       = COORD_WIDTH + SC_WIDTH;
	localparam int SPLIT       = 24;
	localparam int SHI_W       = SPT_W - SPLIT;
	localparam int PPH_W       = MAT_W + SHI_W;
	localparam int PPL_W       = MAT_W + SPLIT + 1;
	localparam int SUMH_W      = PPH_W + 2;
	localparam int SUML_W      = PPL_W + 2;
	localparam int TOTAL_SHIFT = 8 + 2 * 14;
	localparam int TOT_W       = SUMH_W + SPLIT + 2;
	localparam int RND_W       = TOT_W - TOTAL_SHIFT;
	localparam int OSUM_W      = RND_W + 1;

	localparam logic signed [MAT_W-1:0] MAT_ONE = MAT_W'(64'sd268435456);

	// Register reset values.
	localparam logic [Q_WIDTH-1:0]     QUAT_W_RST = 16'h4000;
	localparam logic [SCALE_WIDTH-1:0] SCALE_RST  = 48'h0100_0100_0100;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [Q_WIDTH-1:0]     quat_t;
	typedef logic signed [MAT_W-1:0]       mat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W   = 3'd0,
		REG_QUAT_X   = 3'd1,
		REG_QUAT_Y   = 3'd2,
		REG_QUAT_Z   = 3'd3,
		REG_SCALE    = 3'd4,
		REG_OFFSET_X = 3'd5,
		REG_OFFSET_Y = 3'd6,
		REG_OFFSET_Z = 3'd7
	} cfg_reg_t;

endpackage

// File: hw/rtl/qpt_if.sv
// Input point channel.
interface qpt_point_if import qpt_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// Transformed point channel.
interface qpt_result_if import qpt_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   overflow;

	modport source (output valid, output out_x, output out_y, output out_z, output overflow,
		input ready);
	modport sink   (input valid, input out_x, input out_y, input out_z, input overflow,
		output ready);
endinterface

// Register write channel.
interface qpt_cfg_if import qpt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/quaternion_point_transform.sv
// Channel   Direction  Beat contents
// cfg       in         index (3 bit register number), data (48 bit write value)
// point     in         point_x, point_y, point_z (Q16.16 signed)
// result    out        out_x, out_y, out_z (Q16.16 saturated), overflow
//
// One point enters per cycle unless the result side stalls; each accepted beat passes
// through the five-stage multiply/sum pipeline, every stage holding one beat.
// Reset (arst_n low) empties the pipeline and loads the identity transform.
// A stall on the result side holds a stage only while it is full and the stage ahead of it
// is held, so bubbles close up and no beat is dropped or repeated.
// Register writes are always taken; the rotation matrix follows in the next cycle.
module quaternion_point_transform
	import qpt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	qpt_cfg_if.sink         cfg,
	qpt_point_if.sink       point,
	qpt_result_if.source    result
);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	quat_t                   qw_q, qx_q, qy_q, qz_q;
	logic [SCALE_WIDTH-1:0]  scale_q;
	coord_t                  off_q [3];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q     <= QUAT_W_RST;
			qx_q     <= '0;
			qy_q     <= '0;
			qz_q     <= '0;
			scale_q  <= SCALE_RST;
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_QUAT_W:   qw_q     <= cfg.data[Q_WIDTH-1:0];
				REG_QUAT_X:   qx_q     <= cfg.data[Q_WIDTH-1:0];
				REG_QUAT_Y:   qy_q     <= cfg.data[Q_WIDTH-1:0];
				REG_QUAT_Z:   qz_q     <= cfg.data[Q_WIDTH-1:0];
				REG_SCALE:    scale_q  <= cfg.data[SCALE_WIDTH-1:0];
				REG_OFFSET_X: off_q[0] <= cfg.data[COORD_WIDTH-1:0];
				REG_OFFSET_Y: off_q[1] <= cfg.data[COORD_WIDTH-1:0];
				REG_OFFSET_Z: off_q[2] <= cfg.data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Rotation matrix, rebuilt from the quaternion in the cycle after a write.
	// It is first used by stage 2; a point that enters stage 1 at the same edge as
	// a register write can still meet the matrix built from the old values.
	// ------------------------------------------------------------------
	logic signed [QPROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	mat_t                      mat_d [3][3];
	mat_t                      mat_q [3][3];

	always_comb begin
		xx = qx_q * qx_q;
		yy = qy_q * qy_q;
		zz = qz_q * qz_q;
		xy = qx_q * qy_q;
		xz = qx_q * qz_q;
		yz = qy_q * qz_q;
		wx = qw_q * qx_q;
		wy = qw_q * qy_q;
		wz = qw_q * qz_q;

		mat_d[0][0] = MAT_ONE - ((MAT_W'(yy) + MAT_W'(zz)) <<< 1);
		mat_d[0][1] = (MAT_W'(xy) - MAT_W'(wz)) <<< 1;
		mat_d[0][2] = (MAT_W'(xz) + MAT_W'(wy)) <<< 1;
		mat_d[1][0] = (MAT_W'(xy) + MAT_W'(wz)) <<< 1;
		mat_d[1][1] = MAT_ONE - ((MAT_W'(xx) + MAT_W'(zz)) <<< 1);
		mat_d[1][2] = (MAT_W'(yz) - MAT_W'(wx)) <<< 1;
		mat_d[2][0] = (MAT_W'(xz) - MAT_W'(wy)) <<< 1;
		mat_d[2][1] = (MAT_W'(yz) + MAT_W'(wx)) <<< 1;
		mat_d[2][2] = MAT_ONE - ((MAT_W'(xx) + MAT_W'(yy)) <<< 1);
	end

	always_ff @(posedge clk) begin
		mat_q <= mat_d;
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage takes a new beat when it is empty or
	// when the stage ahead of it is taking its current one.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5      = !v_s5 || result.ready;
	assign rdy_s4      = !v_s4 || rdy_s5;
	assign rdy_s3      = !v_s3 || rdy_s4;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign point.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= point.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: per-axis scale. Q16.16 times Q8.8 gives an exact 48-bit
	// product with 24 fraction bits.
	// ------------------------------------------------------------------
	logic signed [SPT_W-1:0] spt_d [3];
	logic signed [SPT_W-1:0] spt_s1 [3];
	coord_t                  pin [3];

	assign pin[0] = point.point_x;
	assign pin[1] = point.point_y;
	assign pin[2] = point.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			spt_d[i] = pin[i] * $signed(scale_q[SC_WIDTH*i +: SC_WIDTH]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && point.valid) spt_s1 <= spt_d;
	end

	// ------------------------------------------------------------------
	// Stage 2: matrix times scaled point. Each scaled coordinate is split
	// into a signed upper part and an unsigned lower 24 bits so that every
	// multiplier stays near 34 by 25 bits.
	// ------------------------------------------------------------------
	logic signed [PPH_W-1:0] pph_d [3][3];
	logic signed [PPL_W-1:0] ppl_d [3][3];
	logic signed [PPH_W-1:0] pph_s2 [3][3];
	logic signed [PPL_W-1:0] ppl_s2 [3][3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				pph_d[r][c] = mat_q[r][c] * $signed(spt_s1[c][SPT_W-1:SPLIT]);
				ppl_d[r][c] = mat_q[r][c] * $signed({1'b0, spt_s1[c][SPLIT-1:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pph_s2 <= pph_d;
			ppl_s2 <= ppl_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: sum the partial products of each row.
	// ------------------------------------------------------------------
	logic signed [SUMH_W-1:0] sumh_d [3];
	logic signed [SUML_W-1:0] suml_d [3];
	logic signed [SUMH_W-1:0] sumh_s3 [3];
	logic signed [SUML_W-1:0] suml_s3 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sumh_d[r] = SUMH_W'(pph_s2[r][0]) + SUMH_W'(pph_s2[r][1])
				+ SUMH_W'(pph_s2[r][2]);
			suml_d[r] = SUML_W'(ppl_s2[r][0]) + SUML_W'(ppl_s2[r][1])
				+ SUML_W'(ppl_s2[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			sumh_s3 <= sumh_d;
			suml_s3 <= suml_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: join the two halves of the exact sum, add one half LSB of the
	// result and drop 36 fraction bits, which rounds half toward plus infinity.
	// ------------------------------------------------------------------
	logic signed [TOT_W-1:0] tot_d [3];
	logic signed [RND_W-1:0] rnd_s4 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tot_d[r] = (TOT_W'(sumh_s3[r]) <<< SPLIT) + TOT_W'(suml_s3[r])
				+ (TOT_W'(1) <<< (TOTAL_SHIFT - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			for (int r = 0; r < 3; r++) begin
				rnd_s4[r] <= tot_d[r][TOT_W-1:TOTAL_SHIFT];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: add the translation and saturate to 32 bits. This is also the
	// output register.
	// ------------------------------------------------------------------
	logic signed [OSUM_W-1:0] osum_d [3];
	coord_t                   res_d [3];
	logic [2:0]               sat_d;
	coord_t                   res_s5 [3];
	logic                     ovf_s5;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			osum_d[r] = OSUM_W'(rnd_s4[r]) + OSUM_W'(off_q[r]);
			// In range when every bit above the 32-bit sign bit matches it.
			sat_d[r] = !((&osum_d[r][OSUM_W-1:COORD_WIDTH-1])
				|| !(|osum_d[r][OSUM_W-1:COORD_WIDTH-1]));
			if (sat_d[r]) begin
				res_d[r] = osum_d[r][OSUM_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
					: {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end else begin
				res_d[r] = osum_d[r][COORD_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			res_s5 <= res_d;
			ovf_s5 <= |sat_d;
		end
	end

	assign result.valid    = v_s5;
	assign result.out_x    = res_s5[0];
	assign result.out_y    = res_s5[1];
	assign result.out_z    = res_s5[2];
	assign result.overflow = ovf_s5;

`ifndef SYNTHESIS
	// A flagged result has at least one coordinate on a rail.
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && ovf_s5) |->
			(res_s5[0] == {1'b1, {(COORD_WIDTH-1){1'b0}}}
			|| res_s5[0] == {1'b0, {(COORD_WIDTH-1){1'b1}}}
			|| res_s5[1] == {1'b1, {(COORD_WIDTH-1){1'b0}}}
			|| res_s5[1] == {1'b0, {(COORD_WIDTH-1){1'b1}}}
			|| res_s5[2] == {1'b1, {(COORD_WIDTH-1){1'b0}}}
			|| res_s5[2] == {1'b0, {(COORD_WIDTH-1){1'b1}}}))
		else $error("overflow flagged with no saturated coordinate");

	// The input side only backs up when every stage holds a beat.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled while the pipeline has a bubble");

	// An accepted point lands in stage 1.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready) |=> v_s1)
		else $error("accepted point lost at stage 1");

	// A beat leaving stage 4 arrives at the output register.
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && rdy_s5) |=> v_s5)
		else $error("beat lost between stage 4 and the output");
`endif

endmodule

// File: bench/transform_tracker_pkg.sv
`timescale 1ns / 100ps

package transform_tracker_pkg;
	import qpt_pkg::*;

	// Wide enough for every exact product and sum of the transform.
	typedef logic signed [127:0] wide_t;
	typedef logic signed [SC_WIDTH-1:0] axis_scale_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   overflow;
	} transformed_t;

	localparam longint MAT_UNIT = 64'sd1 << 28;

	class transform_tracker;
		quat_t                  quat_w;
		quat_t                  quat_x;
		quat_t                  quat_y;
		quat_t                  quat_z;
		logic [SCALE_WIDTH-1:0] scales;
		coord_t                 offsets [3];
		transformed_t           awaited [$];
		int unsigned            mismatches;
		int unsigned            results_seen;

		function new();
			quat_w       = QUAT_W_RST;
			quat_x       = '0;
			quat_y       = '0;
			quat_z       = '0;
			scales       = SCALE_RST;
			mismatches   = 0;
			results_seen = 0;
			for (int i = 0; i < 3; i++)
				offsets[i] = '0;
		endfunction

		// Bits above a register's width are dropped, as the block does.
		function void note_register(cfg_reg_t index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_QUAT_W:   quat_w = data[Q_WIDTH-1:0];
				REG_QUAT_X:   quat_x = data[Q_WIDTH-1:0];
				REG_QUAT_Y:   quat_y = data[Q_WIDTH-1:0];
				REG_QUAT_Z:   quat_z = data[Q_WIDTH-1:0];
				REG_SCALE:    scales = data[SCALE_WIDTH-1:0];
				REG_OFFSET_X: offsets[0] = data[COORD_WIDTH-1:0];
				REG_OFFSET_Y: offsets[1] = data[COORD_WIDTH-1:0];
				REG_OFFSET_Z: offsets[2] = data[COORD_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// Works out the transformed point: exact products, one rounding at the end
		// (half toward plus infinity), then the offset and saturation.
		function void note_point(coord_t px, coord_t py, coord_t pz);
			longint       w, x, y, z;
			longint       mat [9];
			coord_t       pts [3];
			wide_t        scaled [3];
			wide_t        acc, term, factor, half, top, bottom;
			axis_scale_t  sc;
			transformed_t want;

			w = quat_w;
			x = quat_x;
			y = quat_y;
			z = quat_z;
			mat[0] = MAT_UNIT - 2 * (y * y + z * z);
			mat[1] = 2 * (x * y - w * z);
			mat[2] = 2 * (x * z + w * y);
			mat[3] = 2 * (x * y + w * z);
			mat[4] = MAT_UNIT - 2 * (x * x + z * z);
			mat[5] = 2 * (y * z - w * x);
			mat[6] = 2 * (x * z - w * y);
			mat[7] = 2 * (y * z + w * x);
			mat[8] = MAT_UNIT - 2 * (x * x + y * y);

			pts[0] = px;
			pts[1] = py;
			pts[2] = pz;
			for (int i = 0; i < 3; i++) begin
				sc        = scales[SC_WIDTH*i +: SC_WIDTH];
				term      = pts[i];
				factor    = sc;
				scaled[i] = term * factor;
			end

			half = 1;
			half = half << (TOTAL_SHIFT - 1);
			top = 2147483647;
			bottom = -top - 1;
			want.overflow = 1'b0;
			for (int r = 0; r < 3; r++) begin
				acc = half;
				for (int c = 0; c < 3; c++) begin
					term = mat[3*r + c];
					acc  = acc + term * scaled[c];
				end
				acc  = acc >>> TOTAL_SHIFT;
				term = offsets[r];
				acc  = acc + term;
				if (acc > top) begin
					acc = top;
					want.overflow = 1'b1;
				end else if (acc < bottom) begin
					acc = bottom;
					want.overflow = 1'b1;
				end
				case (r)
					0: want.x = acc[COORD_WIDTH-1:0];
					1: want.y = acc[COORD_WIDTH-1:0];
					default: want.z = acc[COORD_WIDTH-1:0];
				endcase
			end
			awaited.push_back(want);
		endfunction

		function void compare_field(string field, longint want, longint got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(coord_t ox, coord_t oy, coord_t oz, logic ovf);
			transformed_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing expected, got x=%0d y=%0d z=%0d ovf=%0b",
					$time, ox, oy, oz, ovf);
				return;
			end
			want = awaited.pop_front();
			compare_field("out_x", want.x, ox);
			compare_field("out_y", want.y, oy);
			compare_field("out_z", want.z, oz);
			compare_field("overflow", want.overflow, ovf);
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

endpackage

// File: bench/testbench.sv
`timescale 1ns / 100ps

// Point transform bench. Register writes, point beats and result beats are all
// observed at the rising edge by one monitor, which feeds the tracker: register
// writes update its copy of the transform, accepted points queue the expected
// result and result beats are checked in order against that queue.
module testbench;
	import qpt_pkg::*;
	import transform_tracker_pkg::*;

	// Sets the settle time at the end of the run.
	localparam int RESULT_LATENCY  = 5;
	localparam int SETTLE_CYCLES   = 4 * RESULT_LATENCY;
	localparam int IDLE_PERCENT    = 21;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int POINTS_PER_PHASE = 90;
	// Far above the slowest legal run.
	localparam int CYCLE_LIMIT     = 100000;

	logic clk;
	logic arst_n;

	qpt_cfg_if    cfg ();
	qpt_point_if  point ();
	qpt_result_if result ();

	quaternion_point_transform i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.point  (point),
		.result (result)
	);

	transform_tracker tracker;

	// steady_flow and hold_requests are shared between the main sequence and the
	// result receiver. Only the main sequence writes them.
	bit          steady_flow;
	int unsigned hold_requests;
	int unsigned points_sent;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** quaternion_point_transform: FAILED **");
			$finish;
		end
	end

	// Everything is sampled at the edge, before any of this edge's updates land,
	// so the order of processes within the time step does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				tracker.note_register(cfg_reg_t'(cfg.index), cfg.data);
			if (result.valid && result.ready)
				tracker.check_result(result.out_x, result.out_y, result.out_z, result.overflow);
			if (point.valid && point.ready)
				tracker.note_point(point.point_x, point.point_y, point.point_z);
		end
	end

	// Result receiver. It drops ready about a fifth of the time, never while the
	// main sequence asks for steady flow, and holds it low for a long run of
	// cycles each time a hold-off is requested, so the pipeline backs up into
	// the point channel.
	initial begin
		int unsigned holds_done;
		int          hold_left;
		holds_done = 0;
		hold_left  = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else begin
				result.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Writes all eight registers back to back. Only called with the block idle.
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] qw, qx, qy, qz, scale,
			ox, oy, oz);
		write_register(REG_QUAT_W, qw);
		write_register(REG_QUAT_X, qx);
		write_register(REG_QUAT_Y, qy);
		write_register(REG_QUAT_Z, qz);
		write_register(REG_SCALE, scale);
		write_register(REG_OFFSET_X, ox);
		write_register(REG_OFFSET_Y, oy);
		write_register(REG_OFFSET_Z, oz);
		cfg.valid <= 1'b0;
	endtask

	// Offers one point beat, after a random number of idle cycles unless steady
	// flow is asked for. Valid stays high on return so back-to-back beats follow
	// with no idle gap.
	task automatic send_point(input coord_t px, py, pz);
		while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
			point.valid   <= 1'b0;
			point.point_x <= coord_t'($urandom);
			point.point_z <= coord_t'($urandom);
			@(posedge clk);
		end
		point.valid   <= 1'b1;
		point.point_x <= px;
		point.point_y <= py;
		point.point_z <= pz;
		do @(posedge clk); while (!point.ready);
		points_sent++;
	endtask

	// Every point gives exactly one result, so the block is idle once the
	// result count catches up with the point count.
	task automatic wait_for_results();
		point.valid <= 1'b0;
		while (tracker.results_seen < points_sent)
			@(posedge clk);
	endtask

	// Mostly moderate coordinates, so the transform does not saturate on every
	// beat, with full-range values and a few tiny ones that land on rounding ties.
	function automatic coord_t random_coord();
		case ($urandom_range(7))
			0, 1: return coord_t'($urandom);
			2: return coord_t'($urandom_range(8)) - 4;
			default: return coord_t'($urandom) >>> 8;
		endcase
	endfunction

	// A random transform. Quaternion parts stay within +-1.0 most of the time,
	// sometimes take any 16-bit value with junk above bit 15; scales stay within
	// +-2.0 most of the time; offsets are mostly moderate.
	task automatic random_settings();
		logic [CFG_DATA_W-1:0] quat [4];
		logic [CFG_DATA_W-1:0] scale;
		logic [CFG_DATA_W-1:0] offs [3];
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(4) == 0)
				quat[i] = CFG_DATA_W'({$urandom, $urandom});
			else
				quat[i] = CFG_DATA_W'($urandom_range(32768)) - CFG_DATA_W'(16384);
		end
		scale = '0;
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(4) == 0)
				scale[SC_WIDTH*i +: SC_WIDTH] = SC_WIDTH'($urandom);
			else
				scale[SC_WIDTH*i +: SC_WIDTH] = SC_WIDTH'($urandom_range(1024) - 512);
			if ($urandom_range(3) == 0)
				offs[i] = CFG_DATA_W'({$urandom, $urandom});
			else
				offs[i] = CFG_DATA_W'(coord_t'($urandom) >>> 7);
		end
		apply_settings(quat[0], quat[1], quat[2], quat[3], scale, offs[0], offs[1], offs[2]);
	endtask

	initial begin
		tracker       = new();
		steady_flow   = 1'b0;
		hold_requests = 0;
		points_sent   = 0;
		arst_n        <= 1'b0;
		cfg.valid     <= 1'b0;
		cfg.index     <= REG_QUAT_W;
		cfg.data      <= '0;
		point.valid   <= 1'b0;
		point.point_x <= '0;
		point.point_y <= '0;
		point.point_z <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset transform is the identity, so points come back unchanged,
		// including the most positive and most negative coordinates.
		send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
		wait_for_results();

		// Scales of +0.5, -0.5 and the largest positive scale. A one-LSB point
		// scaled by a half is an exact tie: +0.5 rounds up to 1, -0.5 up to 0.
		// Full-range points saturate the z axis and raise the overflow flag.
		apply_settings(QUAT_W_RST, '0, '0, '0, 48'h7FFF_FF80_0080, '0, '0, '0);
		send_point(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);
		send_point(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
		send_point(32'sh0000_0003, 32'sh0000_0003, 32'sh0001_0000);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		wait_for_results();

		// Extreme register values: the most negative quaternion parts, a mix of
		// out-of-range parts, the most negative scales and offsets at both ends.
		// Junk above each register's width must be dropped.
		apply_settings(48'hFFFF_FFFF_8000, 48'h0000_0000_8000, 48'h0000_0000_7FFF,
			48'h0000_0000_C000, 48'h8000_8000_8000, 48'h0000_7FFF_FFFF,
			48'h0000_8000_0000, 48'hFFFF_0000_0000);
		send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
		send_point(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		wait_for_results();

		// A proper rotation: 90 degrees about z. The third point lands exactly one
		// LSB above the largest coordinate once the z offset is added.
		apply_settings(48'd11585, '0, '0, 48'd11585, SCALE_RST, 48'h0000_0001_0000,
			48'h0000_FFFF_0000, 48'h0000_7FFF_0000);
		send_point(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000);
		send_point(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000);
		send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000);
		send_point(random_coord(), random_coord(), random_coord());
		wait_for_results();

		// Non-unit quaternion with every part at +-1.0.
		apply_settings(48'h0000_0000_C000, 48'h0000_0000_4000, 48'h0000_0000_C000,
			48'h0000_0000_4000, SCALE_RST, '0, '0, '0);
		repeat (3) send_point(random_coord(), random_coord(), random_coord());
		wait_for_results();

		// All-zero quaternion and zero scales: every result is the offset alone.
		apply_settings('0, '0, '0, '0, '0, 48'h0000_1234_5678, 48'h0000_8765_4321,
			48'h0000_0000_0001);
		repeat (2) send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
		wait_for_results();

		// Random transforms with random points. One phase runs with no idling on
		// either side; another starts with a long receiver hold-off while points
		// keep coming, so the block fills and stalls its input.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_settings();
			steady_flow = (phase == 1);
			if (phase == 3)
				hold_requests++;
			repeat (POINTS_PER_PHASE)
				send_point(random_coord(), random_coord(), random_coord());
			wait_for_results();
			steady_flow = 1'b0;
		end

		// Give a stray extra beat time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("** quaternion_point_transform: PASSED **");
		else
			$display("** quaternion_point_transform: FAILED **");
		$finish;
	end

endmodule
